>>> rtl/tcw_pkg.sv
package tcw_pkg;

  // Port field widths.
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;

  // Default screen geometry.
  localparam int DEF_SCREEN_COLS = 80;
  localparam int DEF_SCREEN_ROWS = 25;

  // Light grey on black, space character.
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_SETCUR = 2'd3
  } op_t;

  // Request from the control logic to the sweep engine.
  typedef struct packed {
    logic go;
    logic clear_mode;
  } sweep_cmd_t;

  // Status from the sweep engine back to the control logic.
  typedef struct packed {
    logic active;
    logic finish;
  } sweep_stat_t;

endpackage

>>> rtl/tcw_cell_ram.sv
module tcw_cell_ram #(
  parameter int DEPTH = tcw_pkg::DEF_SCREEN_COLS * tcw_pkg::DEF_SCREEN_ROWS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [tcw_pkg::CELL_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [tcw_pkg::CELL_W-1:0]  rd_data
);

  logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/tcw_sweep.sv
module tcw_sweep #(
  parameter int SCREEN_COLS = tcw_pkg::DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = tcw_pkg::DEF_SCREEN_ROWS,
  parameter int AW          = $clog2(SCREEN_COLS * SCREEN_ROWS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tcw_pkg::sweep_cmd_t         cmd,
  output tcw_pkg::sweep_stat_t        stat,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [tcw_pkg::CELL_W-1:0]  rd_data,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [tcw_pkg::CELL_W-1:0]  wr_data
);

  localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int KEEP  = (SCREEN_ROWS - 1) * SCREEN_COLS;
  localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);
  localparam logic [AW-1:0] KEEP_IDX = AW'(KEEP);
  localparam logic [AW-1:0] ROW_STEP = AW'(SCREEN_COLS);

  logic          active;
  logic          clear_mode;
  logic [AW-1:0] idx;
  logic          wr_pend;
  logic [AW-1:0] wr_idx;
  logic          wr_blank;
  logic          blank_now;

  // Cells below the kept region, and every cell of a clear, take the blank.
  assign blank_now = clear_mode || (idx >= KEEP_IDX);

  assign rd_en   = active && !blank_now;
  assign rd_addr = idx + ROW_STEP;

  // Write stage: runs in the cycle after the read, so copied data is the read result.
  assign wr_en   = wr_pend;
  assign wr_addr = wr_idx;
  assign wr_data = wr_blank ? tcw_pkg::BLANK_CELL : rd_data;

  assign stat.active = active || wr_pend;
  assign stat.finish = wr_pend && (wr_idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= active;
      if (cmd.go) begin
        active     <= 1'b1;
        clear_mode <= cmd.clear_mode;
        idx        <= '0;
      end else if (active) begin
        if (idx == LAST_IDX) begin
          active <= 1'b0;
        end else begin
          idx <= idx + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_idx   <= idx;
    wr_blank <= blank_now;
  end

endmodule

>>> rtl/text_console_cell_writer.sv
// Text console cell writer: a SCREEN_ROWS x SCREEN_COLS store of 16-bit cells
// (attribute in the high byte, character in the low byte) and a cursor.
//
// Command channel: a beat is taken at a rising edge where start is high and
// busy is low. Opcodes are put character, read cell, clear screen and set
// cursor. Result channel: every command gives exactly one result beat, shown
// for a single cycle while done is high. The receiver cannot stall it, so it
// must capture the beat in that cycle.
//
// Put and set cursor answer in the cycle after acceptance and busy
// stays low, so these commands may be issued on every cycle. A read inside
// the screen answers after the registered memory read and the read state.
// A clear, or a put that runs off the bottom row, walks the whole cell store
// once, one cell per cycle, and answers after its last cell is written; busy
// is high throughout.
//
// Reset homes the cursor and idles the block. Cell contents are not
// cleared by reset: issue a clear before reading the screen back.
module text_console_cell_writer #(
  parameter int SCREEN_COLS = tcw_pkg::DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = tcw_pkg::DEF_SCREEN_ROWS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
  input  logic [tcw_pkg::ATTR_W-1:0]  attribute,
  input  logic [tcw_pkg::ROW_W-1:0]   target_row,
  input  logic [tcw_pkg::COL_W-1:0]   target_col,
  output logic                        done,
  output logic [tcw_pkg::CELL_W-1:0]  cell_value,
  output logic [tcw_pkg::ROW_W-1:0]   cursor_row_out,
  output logic [tcw_pkg::COL_W-1:0]   cursor_col_out,
  output logic                        did_scroll
);

  localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(SCREEN_ROWS);
  localparam int CW    = $clog2(SCREEN_COLS);
  localparam logic [RW-1:0] LAST_ROW = RW'(SCREEN_ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(SCREEN_COLS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP
  } state_t;

  state_t               state;
  logic [RW-1:0]        cursor_row;
  logic [CW-1:0]        cursor_col;

  tcw_pkg::op_t         op;
  logic                 accept;
  logic                 newline;
  logic                 wrap_row;
  logic                 put_scroll;
  logic [RW-1:0]        put_row_next;
  logic [CW-1:0]        put_col_next;
  logic                 row_in_range;
  logic                 col_in_range;
  logic [AW-1:0]        cursor_idx;
  logic [AW-1:0]        target_idx;

  tcw_pkg::sweep_cmd_t  sweep_cmd;
  tcw_pkg::sweep_stat_t sweep_stat;
  logic                 sw_rd_en;
  logic [AW-1:0]        sw_rd_addr;
  logic                 sw_wr_en;
  logic [AW-1:0]        sw_wr_addr;
  logic [tcw_pkg::CELL_W-1:0] sw_wr_data;

  logic                 ram_wr_en;
  logic [AW-1:0]        ram_wr_addr;
  logic [tcw_pkg::CELL_W-1:0] ram_wr_data;
  logic                 ram_rd_en;
  logic [AW-1:0]        ram_rd_addr;
  logic [tcw_pkg::CELL_W-1:0] ram_rd_data;

  assign op     = tcw_pkg::op_t'(opcode);
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // The cursor is kept on the screen at all times, so its index is always valid.
  assign cursor_idx = AW'(32'(cursor_row) * SCREEN_COLS + 32'(cursor_col));
  assign target_idx = AW'(32'(target_row) * SCREEN_COLS + 32'(target_col));

  assign row_in_range = (32'(target_row) < SCREEN_ROWS);
  assign col_in_range = (32'(target_col) < SCREEN_COLS);

  // Cursor advance for a put. A newline, or a write in the last column,
  // moves to column 0 of the next row; leaving the bottom row scrolls.
  always_comb begin
    newline      = (char_code == tcw_pkg::NEWLINE_CODE);
    wrap_row     = newline || (cursor_col == LAST_COL);
    put_col_next = wrap_row ? '0 : cursor_col + CW'(1);
    put_scroll   = wrap_row && (cursor_row == LAST_ROW);
    if (put_scroll) begin
      put_row_next = LAST_ROW;
    end else if (wrap_row) begin
      put_row_next = cursor_row + RW'(1);
    end else begin
      put_row_next = cursor_row;
    end
  end

  // A clear always sweeps; a put only when it runs off the bottom row.
  always_comb begin
    sweep_cmd.go         = accept && ((op == tcw_pkg::OP_CLEAR) ||
                                      ((op == tcw_pkg::OP_PUT) && put_scroll));
    sweep_cmd.clear_mode = (op == tcw_pkg::OP_CLEAR);
  end

  // Memory port ownership: the sweep engine while sweeping, commands otherwise.
  always_comb begin
    if (state == ST_SWEEP) begin
      ram_wr_en   = sw_wr_en;
      ram_wr_addr = sw_wr_addr;
      ram_wr_data = sw_wr_data;
      ram_rd_en   = sw_rd_en;
      ram_rd_addr = sw_rd_addr;
    end else begin
      ram_wr_en   = accept && (op == tcw_pkg::OP_PUT) && !newline;
      ram_wr_addr = cursor_idx;
      ram_wr_data = {attribute, char_code};
      ram_rd_en   = accept && (op == tcw_pkg::OP_READ) && row_in_range && col_in_range;
      ram_rd_addr = target_idx;
    end
  end

  tcw_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  tcw_sweep #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .AW          (AW)
  ) u_sweep (
    .clk     (clk),
    .rst     (rst),
    .cmd     (sweep_cmd),
    .stat    (sweep_stat),
    .rd_en   (sw_rd_en),
    .rd_addr (sw_rd_addr),
    .rd_data (ram_rd_data),
    .wr_en   (sw_wr_en),
    .wr_addr (sw_wr_addr),
    .wr_data (sw_wr_data)
  );

  // The cursor registers already hold the post-command cursor when done rises.
  assign cursor_row_out = tcw_pkg::ROW_W'(cursor_row);
  assign cursor_col_out = tcw_pkg::COL_W'(cursor_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      did_scroll <= 1'b0;
      cell_value <= '0;
      cursor_row <= '0;
      cursor_col <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cell_value <= '0;
            did_scroll <= 1'b0;
            unique case (op)
              tcw_pkg::OP_PUT: begin
                cursor_row <= put_row_next;
                cursor_col <= put_col_next;
                did_scroll <= put_scroll;
                if (put_scroll) begin
                  state <= ST_SWEEP;
                end else begin
                  done <= 1'b1;
                end
              end
              tcw_pkg::OP_READ: begin
                if (row_in_range && col_in_range) begin
                  state <= ST_READ;
                end else begin
                  done <= 1'b1;
                end
              end
              tcw_pkg::OP_CLEAR: begin
                cursor_row <= '0;
                cursor_col <= '0;
                state      <= ST_SWEEP;
              end
              tcw_pkg::OP_SETCUR: begin
                cursor_row <= row_in_range ? RW'(target_row) : LAST_ROW;
                cursor_col <= col_in_range ? CW'(target_col) : LAST_COL;
                done       <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_READ: begin
          cell_value <= ram_rd_data;
          done       <= 1'b1;
          state      <= ST_IDLE;
        end
        ST_SWEEP: begin
          if (sweep_stat.finish) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/tcw_checker.sv
module tcw_checker #(
  parameter int SCREEN_COLS = tcw_pkg::DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = tcw_pkg::DEF_SCREEN_ROWS
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [1:0]                  opcode,
  input logic                        done,
  input logic [tcw_pkg::CELL_W-1:0]  cell_value,
  input logic [tcw_pkg::ROW_W-1:0]   cursor_row_out,
  input logic                        did_scroll
);

  localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW_OUT = tcw_pkg::ROW_W'(SCREEN_ROWS - 1);

  // No result beat straight out of reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result beat directly after reset");

  // Setting the cursor answers on the very next cycle.
  a_setcur_next: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode == tcw_pkg::OP_SETCUR)) |=> done)
    else $error("set cursor did not answer in one cycle");

  // A clear always holds the command channel off while it sweeps.
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode == tcw_pkg::OP_CLEAR)) |=> (busy && !done))
    else $error("clear did not start a sweep");

  // A scrolling put leaves the cursor on the bottom row and reads no cell.
  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (done && did_scroll) |-> ((cursor_row_out == LAST_ROW_OUT) && (cell_value == '0)))
    else $error("scroll result inconsistent");

endmodule

bind text_console_cell_writer tcw_checker #(
  .SCREEN_COLS (SCREEN_COLS),
  .SCREEN_ROWS (SCREEN_ROWS)
) u_tcw_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .opcode         (opcode),
  .done           (done),
  .cell_value     (cell_value),
  .cursor_row_out (cursor_row_out),
  .did_scroll     (did_scroll)
);

>>> dv/text_console_cell_writer_tb.sv
module text_console_cell_writer_tb;

  // Geometry of the instance under test; the block is built with its defaults.
  localparam int COLS  = tcw_pkg::DEF_SCREEN_COLS;
  localparam int ROWS  = tcw_pkg::DEF_SCREEN_ROWS;
  localparam int CELLS = COLS * ROWS;

  localparam int CELL_W = tcw_pkg::CELL_W;
  localparam int ROW_W  = tcw_pkg::ROW_W;
  localparam int COL_W  = tcw_pkg::COL_W;
  localparam int CHAR_W = tcw_pkg::CHAR_W;
  localparam int ATTR_W = tcw_pkg::ATTR_W;

  localparam int RANDOM_BEATS = 2000;
  // Long enough for a full sweep of the store to finish after the last result,
  // so that a stray late beat would still be seen.
  localparam int DRAIN_CYCLES = CELLS + 64;
  // The slowest correct run has every command sweeping the store behind the
  // longest sender gap, and the limit allows about five times that run.
  localparam int CYCLE_LIMIT = 20_000_000;

  // One result beat, as the block presents it.
  typedef struct packed {
    logic [CELL_W-1:0] cell_word;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              scrolled;
  } console_result_t;

  // One command beat. Where 'typed' is set, 'want' is the result written out
  // by hand; otherwise the result comes from the console predictor below.
  typedef struct {
    tcw_pkg::op_t      op;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    bit                typed;
    console_result_t   want;
  } console_cmd_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [1:0]        opcode = 2'd0;
  logic [CHAR_W-1:0] char_code = '0;
  logic [ATTR_W-1:0] attribute = '0;
  logic [ROW_W-1:0]  target_row = '0;
  logic [COL_W-1:0]  target_col = '0;
  logic              busy;
  logic              done;
  logic [CELL_W-1:0] cell_value;
  logic [ROW_W-1:0]  cursor_row_out;
  logic [COL_W-1:0]  cursor_col_out;
  logic              did_scroll;

  // Shadow copy of the console: cell contents, which cells hold a defined
  // value, and the cursor.
  logic [CELL_W-1:0] screen_cells [CELLS];
  bit                cell_known [CELLS];
  int                cur_row = 0;
  int                cur_col = 0;

  console_cmd_t      directed_cmds [$];
  console_result_t   awaited_results [$];

  // Sender bookkeeping.
  int                beats_issued = 0;
  int                beats_taken = 0;
  int                burst_left = 0;
  int                gap_left = 0;
  bit                held_typed = 1'b0;
  console_result_t   held_want = '0;
  console_result_t   predicted;
  console_cmd_t      upcoming;

  int                failures = 0;
  int                cycle_count = 0;
  console_result_t   oldest;

  text_console_cell_writer uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .char_code      (char_code),
    .attribute      (attribute),
    .target_row     (target_row),
    .target_col     (target_col),
    .done           (done),
    .cell_value     (cell_value),
    .cursor_row_out (cursor_row_out),
    .cursor_col_out (cursor_col_out),
    .did_scroll     (did_scroll)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Reset is held at the start and never raised again.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Applies one command to the shadow console and returns the result beat
  // that the block should give for it.
  function automatic console_result_t console_apply(tcw_pkg::op_t op,
                                                    logic [CHAR_W-1:0] ch,
                                                    logic [ATTR_W-1:0] attr,
                                                    logic [ROW_W-1:0] trow,
                                                    logic [COL_W-1:0] tcol);
    console_result_t res;
    int              idx;
    int              i;
    res = '0;
    case (op)
      tcw_pkg::OP_PUT: begin
        if (ch == tcw_pkg::NEWLINE_CODE) begin
          // A newline moves the cursor but leaves every cell alone.
          cur_col = 0;
          cur_row++;
        end else begin
          idx = cur_row * COLS + cur_col;
          if (idx < CELLS) begin
            screen_cells[idx] = {attr, ch};
            cell_known[idx]   = 1'b1;
          end
          cur_col++;
          if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        // Running off the bottom shifts every row up and blanks the last one.
        if (cur_row >= ROWS) begin
          for (i = 0; i < CELLS - COLS; i++) begin
            screen_cells[i] = screen_cells[i + COLS];
            cell_known[i]   = cell_known[i + COLS];
          end
          for (i = CELLS - COLS; i < CELLS; i++) begin
            screen_cells[i] = tcw_pkg::BLANK_CELL;
            cell_known[i]   = 1'b1;
          end
          cur_row      = ROWS - 1;
          res.scrolled = 1'b1;
        end
      end
      tcw_pkg::OP_READ: begin
        // Anything beyond the screen reads as zero.
        if (trow < ROWS && tcol < COLS) res.cell_word = screen_cells[trow * COLS + tcol];
      end
      tcw_pkg::OP_CLEAR: begin
        for (i = 0; i < CELLS; i++) begin
          screen_cells[i] = tcw_pkg::BLANK_CELL;
          cell_known[i]   = 1'b1;
        end
        cur_row = 0;
        cur_col = 0;
      end
      default: begin
        // Set cursor saturates each coordinate at the screen edge.
        cur_row = (trow < ROWS) ? int'(trow) : ROWS - 1;
        cur_col = (tcol < COLS) ? int'(tcol) : COLS - 1;
      end
    endcase
    res.row = cur_row[ROW_W-1:0];
    res.col = cur_col[COL_W-1:0];
    return res;
  endfunction

  function automatic console_cmd_t console_cmd(tcw_pkg::op_t op, logic [CHAR_W-1:0] ch,
                                               logic [ATTR_W-1:0] attr,
                                               logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                               bit typed, logic [CELL_W-1:0] want_word,
                                               logic [ROW_W-1:0] er, logic [COL_W-1:0] ec,
                                               logic es);
    console_cmd_t cmd;
    cmd.op    = op;
    cmd.ch    = ch;
    cmd.attr  = attr;
    cmd.row   = r;
    cmd.col   = c;
    cmd.typed = typed;
    cmd.want  = {want_word, er, ec, es};
    return cmd;
  endfunction

  // Random commands. Most are puts of random text, with reads that often land
  // on the cursor row and cursor moves that favour the bottom rows and the end
  // of a row, so that wrapping and scrolling happen often. A small share of
  // reads and cursor moves use the whole field range, and clears are rare
  // because each one sweeps the full store.
  function automatic console_cmd_t random_console_cmd();
    console_cmd_t cmd;
    int           pick;
    cmd.typed = 1'b0;
    cmd.want  = '0;
    cmd.ch    = CHAR_W'($urandom);
    cmd.attr  = ATTR_W'($urandom);
    cmd.row   = ROW_W'($urandom);
    cmd.col   = COL_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      cmd.op = tcw_pkg::OP_PUT;
      if ($urandom_range(0, 99) < 6) cmd.ch = tcw_pkg::NEWLINE_CODE;
    end else if (pick < 79) begin
      cmd.op = tcw_pkg::OP_READ;
      if ($urandom_range(0, 9) != 0) begin
        cmd.row = ($urandom_range(0, 1) == 0) ? ROW_W'(cur_row)
                                              : ROW_W'($urandom_range(0, ROWS - 1));
        cmd.col = COL_W'($urandom_range(0, COLS - 1));
      end
      // A cell that holds no defined value yet is never read; such a read is
      // moved below the screen, where it must come back as zero.
      if (cmd.row < ROWS && cmd.col < COLS && !cell_known[cmd.row * COLS + cmd.col])
        cmd.row = ROW_W'($urandom_range(ROWS, (1 << ROW_W) - 1));
    end else if (pick < 98) begin
      cmd.op = tcw_pkg::OP_SETCUR;
      if ($urandom_range(0, 6) != 0) begin
        cmd.row = ($urandom_range(0, 2) == 0) ? ROW_W'($urandom_range(ROWS - 4, ROWS - 1))
                                              : ROW_W'($urandom_range(0, ROWS - 1));
        cmd.col = ($urandom_range(0, 2) == 0) ? COL_W'($urandom_range(COLS - 4, COLS - 1))
                                              : COL_W'($urandom_range(0, COLS - 1));
      end
    end else begin
      cmd.op = tcw_pkg::OP_CLEAR;
    end
    return cmd;
  endfunction

  task automatic note_failure(string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endtask

  // Directed commands. The first put and read run before any clear, on a cell
  // that the put has just defined. Then come reads beyond the screen, cursor
  // moves beyond the screen that must saturate, a scroll caused by writing in
  // the last column of the bottom row, another caused by a newline on the
  // bottom row, a row wrap away from the bottom, and the extreme character
  // and attribute bytes.
  initial begin
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_PUT,    8'h41, 8'h1F, 5'd0,  7'd0,
                                        1, 16'h0000,  0,  1, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_READ,   8'h00, 8'h00, 5'd0,  7'd0,
                                        1, 16'h1F41,  0,  1, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_CLEAR,  8'h00, 8'h00, 5'd0,  7'd0,
                                        1, 16'h0000,  0,  0, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_READ,   8'h00, 8'h00, 5'd24, 7'd79,
                                        1, tcw_pkg::BLANK_CELL, 0, 0, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_READ,   8'h00, 8'h00, 5'd25, 7'd0,
                                        1, 16'h0000,  0,  0, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_READ,   8'h00, 8'h00, 5'd0,  7'd80,
                                        1, 16'h0000,  0,  0, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_READ,   8'hFF, 8'hFF, 5'd31, 7'd127,
                                        1, 16'h0000,  0,  0, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_SETCUR, 8'h00, 8'h00, 5'd31, 7'd127,
                                        1, 16'h0000, 24, 79, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_PUT,    8'hFF, 8'hFF, 5'd0,  7'd0,
                                        1, 16'h0000, 24,  0, 1));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_READ,   8'h00, 8'h00, 5'd23, 7'd79,
                                        1, 16'hFFFF, 24,  0, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_READ,   8'h00, 8'h00, 5'd24, 7'd79,
                                        1, tcw_pkg::BLANK_CELL, 24, 0, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 8'hAA,
                                        5'd0, 7'd0, 1, 16'h0000, 24,  0, 1));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_READ,   8'h00, 8'h00, 5'd22, 7'd79,
                                        1, 16'hFFFF, 24,  0, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_READ,   8'h00, 8'h00, 5'd24, 7'd0,
                                        1, tcw_pkg::BLANK_CELL, 24, 0, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_SETCUR, 8'h00, 8'h00, 5'd3,  7'd78,
                                        1, 16'h0000,  3, 78, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_PUT,    8'h00, 8'h00, 5'd0,  7'd0,
                                        1, 16'h0000,  3, 79, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_PUT,    8'h7E, 8'h80, 5'd0,  7'd0,
                                        1, 16'h0000,  4,  0, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_READ,   8'h00, 8'h00, 5'd3,  7'd78,
                                        1, 16'h0000,  4,  0, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_READ,   8'h00, 8'h00, 5'd3,  7'd79,
                                        1, 16'h807E,  4,  0, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_SETCUR, 8'h00, 8'h00, 5'd10, 7'd40,
                                        1, 16'h0000, 10, 40, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 8'h55,
                                        5'd0, 7'd0, 1, 16'h0000, 11,  0, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_SETCUR, 8'h00, 8'h00, 5'd24, 7'd127,
                                        1, 16'h0000, 24, 79, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_SETCUR, 8'h00, 8'h00, 5'd30, 7'd0,
                                        1, 16'h0000, 24,  0, 0));
    // From here on the rows are checked against the predictor.
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_PUT,    8'h3C, 8'h5A, 5'd0,  7'd0,
                                        0, 16'h0000,  0,  0, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_READ,   8'h00, 8'h00, 5'd24, 7'd0,
                                        0, 16'h0000,  0,  0, 0));
    directed_cmds.push_back(console_cmd(tcw_pkg::OP_SETCUR, 8'h00, 8'h00, 5'd0,  7'd127,
                                        0, 16'h0000,  0,  0, 0));
  end

  // Sender. A beat is taken at an edge where start is high and busy is low;
  // its expected result is worked out right then, so the shadow console always
  // matches what the block has accepted. The next command is chosen in the same
  // step, from that same state. Commands go out in bursts of random length with
  // random gaps between them, and some bursts follow each other with no gap.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predicted = console_apply(tcw_pkg::op_t'(opcode), char_code, attribute,
                                  target_row, target_col);
        awaited_results.push_back(held_typed ? held_want : predicted);
        beats_taken++;
      end
      if (!start || !busy) begin
        if (beats_issued == directed_cmds.size() + RANDOM_BEATS) begin
          start <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else begin
          upcoming = (beats_issued < directed_cmds.size()) ? directed_cmds[beats_issued]
                                                           : random_console_cmd();
          start      <= 1'b1;
          opcode     <= upcoming.op;
          char_code  <= upcoming.ch;
          attribute  <= upcoming.attr;
          target_row <= upcoming.row;
          target_col <= upcoming.col;
          held_typed = upcoming.typed;
          held_want  = upcoming.want;
          beats_issued++;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // Result checker. The receiver cannot stall the block, so every cycle with
  // done high is a beat that must match the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        note_failure($sformatf("unexpected result beat: cell %h row %0d col %0d scroll %0b",
                               cell_value, cursor_row_out, cursor_col_out, did_scroll));
      end else begin
        oldest = awaited_results.pop_front();
        if (cell_value !== oldest.cell_word || cursor_row_out !== oldest.row ||
            cursor_col_out !== oldest.col || did_scroll !== oldest.scrolled)
          note_failure($sformatf({"result mismatch: expected cell %h row %0d col %0d",
                                  " scroll %0b, got cell %h row %0d col %0d scroll %0b"},
                                 oldest.cell_word, oldest.row, oldest.col, oldest.scrolled,
                                 cell_value, cursor_row_out, cursor_col_out, did_scroll));
      end
    end
  end

  // End of run: every command taken and answered, then a quiet stretch long
  // enough for any stray beat to show up.
  initial begin
    @(negedge clk);
    while (rst || beats_taken < directed_cmds.size() + RANDOM_BEATS ||
           awaited_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
